FILE: rtl/lscr_pkg.sv
// Shared types and constants for the line scan camera readout block.
// No dependencies; used by lscr_avg and line_scan_camera_readout.
package lscr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int NUM_SAMPLES = 8;
	localparam int COUNT_W     = 9;
	localparam int INDEX_W     = 8;
	localparam int END_COUNT_DEF = 129;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ADC   = 2'd1,
		OP_START = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_DUAL = 2'd0,
		MODE_CAM1 = 2'd1,
		MODE_CAM2 = 2'd2
	} mode_t;

	// Write enables from the averager to the result stage
	typedef struct packed {
		logic wr_cam1;
		logic wr_cam2;
	} pixel_wr_t;

endpackage

FILE: rtl/line_scan_camera_readout.sv
// Top level of the line scan camera readout sequencer: input stage, sequence
// state, result stage. Depends on lscr_pkg and lscr_avg.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | op, sample_0 .. sample_7
//  out     | out_valid/out_ready | si_level .. pixel_index, frame_done
//  cfg     | cfg_valid/cfg_ready | camera_mode
//
// Each item passes through the input register, then the result register.
// One item per cycle is sustained while the output is ready.
// Sequence state updates as an item moves from the input to the result stage.
// A stalled output holds both stages; the input stays ready while either
// stage can move. Reset stops the sequence, clears counter and pins, mode 0.
module line_scan_camera_readout #(
	parameter int END_COUNT = lscr_pkg::END_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_0,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_1,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_2,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_3,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_4,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_5,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_6,
	input  logic [lscr_pkg::SAMPLE_W-1:0] sample_7,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          si_level,
	output logic                          clock_level,
	output logic                          clock_pulse,
	output logic                          start_conversion,
	output logic                          write_cam1,
	output logic                          write_cam2,
	output logic [lscr_pkg::SAMPLE_W-1:0] pixel_cam1,
	output logic [lscr_pkg::SAMPLE_W-1:0] pixel_cam2,
	output logic [lscr_pkg::INDEX_W-1:0]  pixel_index,
	output logic                          frame_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    camera_mode
);

	typedef enum logic [2:0] {
		PH_STOPPED,
		PH_ARMED,
		PH_SI_HIGH,
		PH_SI_LOW,
		PH_CLK_HIGH,
		PH_CLK_LOW
	} phase_t;

	localparam logic [lscr_pkg::COUNT_W-1:0] END_CNT = lscr_pkg::COUNT_W'(END_COUNT);

	// input stage
	logic                          valid_s1;
	logic [1:0]                    op_s1;
	logic [lscr_pkg::SAMPLE_W-1:0] sample_s1 [lscr_pkg::NUM_SAMPLES];
	logic                          adv_s1;

	// sequence state
	phase_t                        phase_q, phase_d, phase_eff;
	logic [lscr_pkg::COUNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic                          si_q, si_d;
	logic                          clk_q, clk_d;
	logic [1:0]                    mode_q;
	logic                          pulse_d, conv_d, done_d;

	// averager
	lscr_pkg::pixel_wr_t           wr;
	logic [lscr_pkg::SAMPLE_W-1:0] pix1, pix2;

	// result stage
	logic                          valid_s2;

	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1        <= op;
			sample_s1[0] <= sample_0;
			sample_s1[1] <= sample_1;
			sample_s1[2] <= sample_2;
			sample_s1[3] <= sample_3;
			sample_s1[4] <= sample_4;
			sample_s1[5] <= sample_5;
			sample_s1[6] <= sample_6;
			sample_s1[7] <= sample_7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lscr_pkg::MODE_DUAL;
		end else if (cfg_valid) begin
			mode_q <= camera_mode;
		end
	end

	assign cnt_inc   = cnt_q + 1'b1;
	// an armed sequence starts straight away with the SI raise
	assign phase_eff = (phase_q == PH_ARMED) ? PH_SI_HIGH : phase_q;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		si_d    = si_q;
		clk_d   = clk_q;
		pulse_d = 1'b0;
		conv_d  = 1'b0;
		done_d  = 1'b0;
		case (op_s1)
			lscr_pkg::OP_TICK: begin
				case (phase_eff)
					PH_SI_HIGH: begin
						si_d    = 1'b1;
						phase_d = PH_SI_LOW;
					end
					PH_SI_LOW: begin
						si_d    = 1'b0;
						cnt_d   = '1;
						phase_d = PH_CLK_HIGH;
					end
					PH_CLK_HIGH: begin
						cnt_d = cnt_inc;
						if (cnt_inc == END_CNT) begin
							clk_d   = 1'b0;
							pulse_d = 1'b1;
							done_d  = 1'b1;
							phase_d = PH_STOPPED;
						end else begin
							clk_d   = 1'b1;
							phase_d = PH_CLK_LOW;
						end
					end
					PH_CLK_LOW: begin
						conv_d  = 1'b1;
						clk_d   = 1'b0;
						phase_d = PH_CLK_HIGH;
					end
					default: begin
						phase_d = PH_STOPPED;
					end
				endcase
			end
			lscr_pkg::OP_START: begin
				phase_d = PH_ARMED;
			end
			default: begin
				// conversion done and unused codes leave the sequence alone
			end
		endcase
	end

	lscr_avg u_avg (
		.en         (op_s1 == lscr_pkg::OP_ADC),
		.mode       (mode_q),
		.sample     (sample_s1),
		.wr         (wr),
		.pixel_cam1 (pix1),
		.pixel_cam2 (pix2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_STOPPED;
			cnt_q            <= '0;
			si_q             <= 1'b0;
			clk_q            <= 1'b0;
			valid_s2         <= 1'b0;
			si_level         <= 1'b0;
			clock_level      <= 1'b0;
			clock_pulse      <= 1'b0;
			start_conversion <= 1'b0;
			write_cam1       <= 1'b0;
			write_cam2       <= 1'b0;
			pixel_cam1       <= '0;
			pixel_cam2       <= '0;
			pixel_index      <= '0;
			frame_done       <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q          <= phase_d;
				cnt_q            <= cnt_d;
				si_q             <= si_d;
				clk_q            <= clk_d;
				si_level         <= si_d;
				clock_level      <= clk_d;
				clock_pulse      <= pulse_d;
				start_conversion <= conv_d;
				write_cam1       <= wr.wr_cam1;
				write_cam2       <= wr.wr_cam2;
				pixel_cam1       <= pix1;
				pixel_cam2       <= pix2;
				pixel_index      <= cnt_d[lscr_pkg::INDEX_W-1:0];
				frame_done       <= done_d;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: rtl/lscr_avg.sv
// Sample averager: averages the eight ADC samples into one or two pixel values.
// Depends on lscr_pkg for widths, mode codes and the write-enable struct.
module lscr_avg (
	input  logic                               en,
	input  logic [1:0]                         mode,
	input  logic [lscr_pkg::SAMPLE_W-1:0]      sample [lscr_pkg::NUM_SAMPLES],
	output lscr_pkg::pixel_wr_t                wr,
	output logic [lscr_pkg::SAMPLE_W-1:0]      pixel_cam1,
	output logic [lscr_pkg::SAMPLE_W-1:0]      pixel_cam2
);

	logic [lscr_pkg::SAMPLE_W+1:0] sum_lo;
	logic [lscr_pkg::SAMPLE_W+1:0] sum_hi;
	logic [lscr_pkg::SAMPLE_W+2:0] sum_all;
	logic [lscr_pkg::SAMPLE_W-1:0] avg_lo;
	logic [lscr_pkg::SAMPLE_W-1:0] avg_hi;
	logic [lscr_pkg::SAMPLE_W-1:0] avg_all;

	assign sum_lo = (lscr_pkg::SAMPLE_W+2)'(sample[0]) + (lscr_pkg::SAMPLE_W+2)'(sample[1])
		+ (lscr_pkg::SAMPLE_W+2)'(sample[2]) + (lscr_pkg::SAMPLE_W+2)'(sample[3]);
	assign sum_hi = (lscr_pkg::SAMPLE_W+2)'(sample[4]) + (lscr_pkg::SAMPLE_W+2)'(sample[5])
		+ (lscr_pkg::SAMPLE_W+2)'(sample[6]) + (lscr_pkg::SAMPLE_W+2)'(sample[7]);
	assign sum_all = (lscr_pkg::SAMPLE_W+3)'(sum_lo) + (lscr_pkg::SAMPLE_W+3)'(sum_hi);

	assign avg_lo  = sum_lo[lscr_pkg::SAMPLE_W+1:2];
	assign avg_hi  = sum_hi[lscr_pkg::SAMPLE_W+1:2];
	assign avg_all = sum_all[lscr_pkg::SAMPLE_W+2:3];

	always_comb begin
		wr.wr_cam1 = 1'b0;
		wr.wr_cam2 = 1'b0;
		pixel_cam1 = '0;
		pixel_cam2 = '0;
		if (en) begin
			case (mode)
				lscr_pkg::MODE_DUAL: begin
					wr.wr_cam1 = 1'b1;
					wr.wr_cam2 = 1'b1;
					pixel_cam1 = avg_lo;
					pixel_cam2 = avg_hi;
				end
				lscr_pkg::MODE_CAM1: begin
					wr.wr_cam1 = 1'b1;
					pixel_cam1 = avg_all;
				end
				lscr_pkg::MODE_CAM2: begin
					wr.wr_cam2 = 1'b1;
					pixel_cam2 = avg_all;
				end
				default: begin
					// unused mode code: no write
				end
			endcase
		end
	end

endmodule

FILE: test/line_scan_camera_readout_test.sv
// Self-checking bench for line_scan_camera_readout: a directed script, then
// random readout frames under all four camera modes, checked by a local model.
// Depends on lscr_pkg and the RTL of the block.
module line_scan_camera_readout_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_END      = lscr_pkg::END_COUNT_DEF;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_ITEMS   = 200;

	localparam logic [1:0] OP_RESERVED   = 2'd3;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	typedef enum logic [2:0] {
		SEQ_STOPPED,
		SEQ_ARMED,
		SEQ_SI_HIGH,
		SEQ_SI_LOW,
		SEQ_CLK_HIGH,
		SEQ_CLK_LOW
	} seq_phase_t;

	typedef struct packed {
		logic        si_level;
		logic        clock_level;
		logic        clock_pulse;
		logic        start_conversion;
		logic        write_cam1;
		logic        write_cam2;
		logic [15:0] pixel_cam1;
		logic [15:0] pixel_cam2;
		logic [7:0]  pixel_index;
		logic        frame_done;
	} readout_t;

	typedef struct {
		logic [1:0]       op;
		logic [7:0][15:0] smp;
		bit               typed;
		readout_t         want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0] op, camera_mode;
	logic [15:0] sample_0, sample_1, sample_2, sample_3;
	logic [15:0] sample_4, sample_5, sample_6, sample_7;
	logic si_level, clock_level, clock_pulse, start_conversion;
	logic write_cam1, write_cam2, frame_done;
	logic [15:0] pixel_cam1, pixel_cam2;
	logic [7:0] pixel_index;

	// Local copy of the sequencer state
	seq_phase_t seq_phase = SEQ_STOPPED;
	logic [8:0] pixel_count = '0;
	logic       pin_si = 1'b0;
	logic       pin_clk = 1'b0;
	logic [1:0] cam_mode = lscr_pkg::MODE_DUAL;
	logic       conv_pending = 1'b0;

	readout_t expected_readouts[$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int frames_seen = 0;
	int cycle_count = 0;
	int idle_max = 3;
	bit long_hold = 1'b0;

	logic [1:0] mode_plan [6] = '{lscr_pkg::MODE_CAM1, lscr_pkg::MODE_CAM2, MODE_RESERVED,
		lscr_pkg::MODE_DUAL, lscr_pkg::MODE_CAM1, lscr_pkg::MODE_DUAL};

	script_row_t opening_rows [16] = '{
		'{lscr_pkg::OP_TICK, '0, 1'b1, '0},
		'{lscr_pkg::OP_ADC, {8{16'hFFFF}}, 1'b1, '{write_cam1: 1'b1, write_cam2: 1'b1,
			pixel_cam1: 16'hFFFF, pixel_cam2: 16'hFFFF, default: '0}},
		'{lscr_pkg::OP_ADC, '0, 1'b1, '{write_cam1: 1'b1, write_cam2: 1'b1, default: '0}},
		'{OP_RESERVED, {8{16'hFFFF}}, 1'b1, '0},
		'{lscr_pkg::OP_START, '0, 1'b1, '0},
		'{lscr_pkg::OP_TICK, '0, 1'b1, '{si_level: 1'b1, default: '0}},
		'{lscr_pkg::OP_TICK, '0, 1'b1, '{pixel_index: 8'd255, default: '0}},
		'{lscr_pkg::OP_ADC, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd2},
			1'b0, '0},
		'{lscr_pkg::OP_TICK, '0, 1'b1, '{clock_level: 1'b1, default: '0}},
		'{lscr_pkg::OP_TICK, '0, 1'b1, '{start_conversion: 1'b1, default: '0}},
		'{lscr_pkg::OP_ADC, {4{16'h8000, 16'h7FFF}}, 1'b0, '0},
		'{lscr_pkg::OP_TICK, '0, 1'b0, '0},
		'{lscr_pkg::OP_START, '0, 1'b0, '0},
		'{lscr_pkg::OP_TICK, '0, 1'b0, '0},
		'{OP_RESERVED, '0, 1'b0, '0},
		'{lscr_pkg::OP_TICK, '0, 1'b0, '0}
	};

	line_scan_camera_readout #(.END_COUNT(LINE_END)) dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .op,
		.sample_0, .sample_1, .sample_2, .sample_3,
		.sample_4, .sample_5, .sample_6, .sample_7,
		.out_valid, .out_ready,
		.si_level, .clock_level, .clock_pulse, .start_conversion,
		.write_cam1, .write_cam2, .pixel_cam1, .pixel_cam2,
		.pixel_index, .frame_done,
		.cfg_valid, .cfg_ready, .camera_mode
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Advance the local sequencer by one item and return the readout it causes
	function automatic readout_t predict_readout(logic [1:0] op_code,
			logic [7:0][15:0] smp);
		readout_t r;
		seq_phase_t ph;
		logic [18:0] sum_lo, sum_hi;
		r = '0;
		sum_lo = smp[0] + smp[1] + smp[2] + smp[3];
		sum_hi = smp[4] + smp[5] + smp[6] + smp[7];
		case (op_code)
			lscr_pkg::OP_TICK: begin
				ph = seq_phase;
				// armed behaves like the SI-raise phase
				if (ph == SEQ_ARMED)
					ph = SEQ_SI_HIGH;
				case (ph)
					SEQ_SI_HIGH: begin
						pin_si = 1'b1;
						seq_phase = SEQ_SI_LOW;
					end
					SEQ_SI_LOW: begin
						pin_si = 1'b0;
						pixel_count = '1;
						seq_phase = SEQ_CLK_HIGH;
					end
					SEQ_CLK_HIGH: begin
						pixel_count = pixel_count + 9'd1;
						if (pixel_count == LINE_END) begin
							pin_clk = 1'b0;
							r.clock_pulse = 1'b1;
							r.frame_done = 1'b1;
							seq_phase = SEQ_STOPPED;
						end else begin
							pin_clk = 1'b1;
							seq_phase = SEQ_CLK_LOW;
						end
					end
					SEQ_CLK_LOW: begin
						r.start_conversion = 1'b1;
						pin_clk = 1'b0;
						seq_phase = SEQ_CLK_HIGH;
					end
					default: seq_phase = SEQ_STOPPED;
				endcase
			end
			lscr_pkg::OP_ADC: begin
				case (cam_mode)
					lscr_pkg::MODE_DUAL: begin
						r.write_cam1 = 1'b1;
						r.write_cam2 = 1'b1;
						r.pixel_cam1 = 16'(sum_lo >> 2);
						r.pixel_cam2 = 16'(sum_hi >> 2);
					end
					lscr_pkg::MODE_CAM1: begin
						r.write_cam1 = 1'b1;
						r.pixel_cam1 = 16'((sum_lo + sum_hi) >> 3);
					end
					lscr_pkg::MODE_CAM2: begin
						r.write_cam2 = 1'b1;
						r.pixel_cam2 = 16'((sum_lo + sum_hi) >> 3);
					end
					default: ;
				endcase
			end
			lscr_pkg::OP_START: seq_phase = SEQ_ARMED;
			default: ;
		endcase
		r.si_level = pin_si;
		r.clock_level = pin_clk;
		r.pixel_index = pixel_count[7:0];
		return r;
	endfunction

	// Mostly well-formed frames: start, ticks, a conversion after each clock-low
	function automatic logic [1:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			case ($urandom_range(0, 2))
				0: return lscr_pkg::OP_TICK;
				1: return lscr_pkg::OP_ADC;
				default: return OP_RESERVED;
			endcase
		end
		if (conv_pending)
			return lscr_pkg::OP_ADC;
		if (seq_phase == SEQ_STOPPED)
			return (roll < 70) ? lscr_pkg::OP_START
				: ((roll < 85) ? lscr_pkg::OP_ADC : lscr_pkg::OP_TICK);
		// rare restart in the middle of a frame
		if ($urandom_range(0, 999) < 2)
			return lscr_pkg::OP_START;
		return (roll < 88) ? lscr_pkg::OP_TICK : lscr_pkg::OP_ADC;
	endfunction

	function automatic logic [15:0] draw_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_item(logic [1:0] op_code, logic [7:0][15:0] smp, bit typed,
			readout_t want);
		int gap;
		readout_t r;
		gap = $urandom_range(0, idle_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= op_code;
		sample_0 <= smp[0];
		sample_1 <= smp[1];
		sample_2 <= smp[2];
		sample_3 <= smp[3];
		sample_4 <= smp[4];
		sample_5 <= smp[5];
		sample_6 <= smp[6];
		sample_7 <= smp[7];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_readout(op_code, smp);
		conv_pending = r.start_conversion;
		expected_readouts.push_back(typed ? want : r);
		items_sent++;
	endtask

	// Change the mode only once the block has drained
	task automatic write_mode(logic [1:0] m);
		@(negedge clk) in_valid <= 1'b0;
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		camera_mode <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cam_mode = m;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls per result, one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = long_hold ? HOLD_CYCLES : $urandom_range(0, idle_max);
			long_hold = 1'b0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		readout_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readouts.size() == 0) begin
				$error("readout transfer with nothing expected");
				mismatches++;
			end else begin
				want = expected_readouts.pop_front();
				check_field("si_level", want.si_level, si_level);
				check_field("clock_level", want.clock_level, clock_level);
				check_field("clock_pulse", want.clock_pulse, clock_pulse);
				check_field("start_conversion", want.start_conversion, start_conversion);
				check_field("write_cam1", want.write_cam1, write_cam1);
				check_field("write_cam2", want.write_cam2, write_cam2);
				check_field("pixel_cam1", want.pixel_cam1, pixel_cam1);
				check_field("pixel_cam2", want.pixel_cam2, pixel_cam2);
				check_field("pixel_index", want.pixel_index, pixel_index);
				check_field("frame_done", want.frame_done, frame_done);
				results_seen++;
				if (want.frame_done)
					frames_seen++;
			end
		end
	end

	initial begin
		logic [7:0][15:0] smp;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = lscr_pkg::OP_TICK;
		{sample_0, sample_1, sample_2, sample_3} = '0;
		{sample_4, sample_5, sample_6, sample_7} = '0;
		cfg_valid = 1'b0;
		camera_mode = lscr_pkg::MODE_DUAL;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (opening_rows[i])
			push_item(opening_rows[i].op, opening_rows[i].smp, opening_rows[i].typed,
				opening_rows[i].want);

		foreach (mode_plan[p]) begin
			write_mode(mode_plan[p]);
			// one phase runs with no idling on either side
			idle_max = (p == 3) ? 0 : 3;
			if (p == 1)
				long_hold = 1'b1;
			repeat (PHASE_ITEMS) begin
				for (int k = 0; k < 8; k++)
					smp[k] = draw_sample();
				push_item(pick_op(), smp, 1'b0, '0);
			end
		end

		@(negedge clk) in_valid <= 1'b0;
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d input transfers and %0d readouts, %0d complete line frames,",
			items_sent, results_seen, frames_seen);
		$display("across dual, single and unused camera modes with random stalls.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lscr_pkg.sv
rtl/lscr_avg.sv
rtl/line_scan_camera_readout.sv
test/line_scan_camera_readout_test.sv
